@@ sv/uee_pkg.sv @@
// Package for the backslash-u escape decoder.
// Holds the character constants, queue sizes, result word type and hex helpers.
// No dependencies.
package uee_pkg;

  // Lookahead window: backslash, 'u' and four hex digits
  localparam int LA_DEPTH   = 6;
  localparam int KEEP_DEPTH = LA_DEPTH - 1;
  // Result queue: room for one full burst on top of words still waiting
  localparam int Q_DEPTH    = 12;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;
  localparam logic [7:0] ESC_LIMIT   = 8'hFF;

  typedef logic [2:0] la_cnt_t;
  typedef logic [3:0] q_cnt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } res_word_t;

  // True for 0-9, A-F, a-f
  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Nibble value of a hex digit; zero for anything else
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

@@ sv/unicode_escape_unescaper.sv @@
// Backslash-u escape decoder, top level.
// Uses uee_pkg for constants, the result word type and hex helpers.
//
// Takes one string byte per cycle and returns the unescaped bytes. A word is
// registered on entry, decoded in one pass against the held lookahead bytes,
// and its zero to six results are written into a twelve-word queue that
// drives the output port one word per cycle while m_tready is high. A byte
// is taken every cycle while at least six queue slots are free; a burst (six
// words for an escape of value 255 or more, up to five for a flush) can hold
// the input back until the queue drains. Each byte is held in the input
// register, then its results in the queue. After a bad escape one word
// with parse_error set closes the string and later bytes up to the last are dropped.
module unicode_escape_unescaper (
  input  logic       clk,
  input  logic       rst,
  // slave side
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // string_last
  // master side
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // string_end
  output logic       m_tuser    // [0] parse_error
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Decoder state
  logic [7:0]       la_buf [uee_pkg::KEEP_DEPTH];
  uee_pkg::la_cnt_t la_cnt;
  logic             swallow;
  uee_pkg::la_cnt_t la_cnt_next;
  logic             swallow_next;

  // Result queue
  uee_pkg::res_word_t q [uee_pkg::Q_DEPTH];
  uee_pkg::res_word_t q_next [uee_pkg::Q_DEPTH];
  uee_pkg::q_cnt_t    q_count;
  uee_pkg::q_cnt_t    q_count_next;
  uee_pkg::q_cnt_t    base;

  // Decode pass
  logic [7:0]         full [uee_pkg::LA_DEPTH];
  logic               hex_ok;
  logic [15:0]        hex_val;
  logic               dec_ok;
  uee_pkg::la_cnt_t   res_n;
  logic               res_dec;
  logic               res_err;
  uee_pkg::res_word_t res [uee_pkg::LA_DEPTH];

  logic room;
  logic proc;
  logic pop;

  assign room     = (q_count <= uee_pkg::q_cnt_t'(uee_pkg::Q_DEPTH - uee_pkg::LA_DEPTH));
  assign proc     = in_valid && room;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = !in_valid || room;

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = q[0].data;
  assign m_tlast  = q[0].last;
  assign m_tuser  = q[0].err;

  // Hold the incoming word until the queue has room for its results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Window of held bytes with the new byte appended at position la_cnt
  always_comb begin
    for (int i = 0; i < uee_pkg::KEEP_DEPTH; i++) begin
      full[i] = (uee_pkg::la_cnt_t'(i) == la_cnt) ? in_byte : la_buf[i];
    end
    full[uee_pkg::LA_DEPTH - 1] = in_byte;
  end

  // Check the four digits after backslash-u
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    for (int i = 2; i < uee_pkg::LA_DEPTH; i++) begin
      hex_ok  = hex_ok && uee_pkg::is_hex(full[i]);
      hex_val = {hex_val[11:0], uee_pkg::hex_nib(full[i])};
    end
    dec_ok = hex_ok && (hex_val[15:8] == 8'h00) && (hex_val[7:0] != uee_pkg::ESC_LIMIT);
  end

  // Decide how many bytes leave the window and what is kept
  always_comb begin
    res_n        = '0;
    res_dec      = 1'b0;
    res_err      = 1'b0;
    la_cnt_next  = la_cnt;
    swallow_next = swallow;
    if (swallow) begin
      if (in_last) begin
        swallow_next = 1'b0;
      end
    end else if (la_cnt == uee_pkg::la_cnt_t'(uee_pkg::KEEP_DEPTH)) begin
      la_cnt_next = '0;
      if (!hex_ok) begin
        res_n        = 3'd1;
        res_err      = 1'b1;
        swallow_next = !in_last;
      end else if (dec_ok) begin
        res_n   = 3'd1;
        res_dec = 1'b1;
      end else begin
        res_n = uee_pkg::la_cnt_t'(uee_pkg::LA_DEPTH);
      end
    end else if (in_last) begin
      // flush everything raw
      res_n       = la_cnt + 3'd1;
      la_cnt_next = '0;
    end else begin
      case (la_cnt)
        3'd0: begin
          if (in_byte == uee_pkg::CHAR_BSLASH) begin
            la_cnt_next = 3'd1;
          end else begin
            res_n = 3'd1;
          end
        end
        3'd1: begin
          if (in_byte == uee_pkg::CHAR_U) begin
            la_cnt_next = 3'd2;
          end else begin
            // backslash pair or lone backslash: both bytes pass
            res_n       = 3'd2;
            la_cnt_next = '0;
          end
        end
        default: begin
          la_cnt_next = la_cnt + 3'd1;
        end
      endcase
    end
  end

  // Build the result words
  always_comb begin
    for (int j = 0; j < uee_pkg::LA_DEPTH; j++) begin
      if (res_err) begin
        res[j].data = 8'h00;
        res[j].last = 1'b1;
      end else begin
        res[j].data = res_dec ? hex_val[7:0] : full[j];
        res[j].last = in_last && (uee_pkg::la_cnt_t'(j) == res_n - 3'd1);
      end
      res[j].err = res_err;
    end
  end

  // Advance the decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      la_cnt  <= '0;
      swallow <= 1'b0;
    end else if (proc) begin
      la_cnt  <= la_cnt_next;
      swallow <= swallow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < uee_pkg::KEEP_DEPTH; i++) begin
        la_buf[i] <= full[i];
      end
    end
  end

  // Pop the head word, then append the new results behind what remains
  always_comb begin
    logic [3:0] j;
    base = q_count - uee_pkg::q_cnt_t'(pop);
    for (int i = 0; i < uee_pkg::Q_DEPTH; i++) begin
      if (pop && (i + 1 < uee_pkg::Q_DEPTH)) begin
        q_next[i] = q[(i + 1) % uee_pkg::Q_DEPTH];
      end else begin
        q_next[i] = q[i];
      end
      j = uee_pkg::q_cnt_t'(i) - base;
      if (proc && (uee_pkg::q_cnt_t'(i) >= base) && (j < {1'b0, res_n})) begin
        q_next[i] = res[j[2:0]];
      end
    end
    q_count_next = base + (proc ? {1'b0, res_n} : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < uee_pkg::Q_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

@@ tb/sv/unicode_escape_unescaper_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the backslash-u escape decoder: directed and random strings,
// checked word by word against a behavioral decoder held in a scoreboard class.
// Depends on uee_pkg and unicode_escape_unescaper.
module unicode_escape_unescaper_tb;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_BYTES = 500;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT_WORD = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_GAP = 6;

  // Expected-word store with its own copy of the decoder state
  class unescape_model;
    logic [7:0]         la_buf[uee_pkg::LA_DEPTH];
    int                 la_cnt;
    bit                 swallowing;
    uee_pkg::res_word_t expected_words[$];
    int                 errors;

    function new();
      foreach (la_buf[i]) la_buf[i] = 8'h00;
      la_cnt = 0;
      swallowing = 0;
      errors = 0;
    endfunction

    // Nibble of a hex digit, -1 for anything else
    static function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function void clear_window();
      foreach (la_buf[i]) la_buf[i] = 8'h00;
      la_cnt = 0;
    endfunction

    function void drop_front(int k);
      if (k >= la_cnt) begin
        la_cnt = 0;
      end else begin
        for (int i = 0; i < la_cnt - k; i++) la_buf[i] = la_buf[i + k];
        la_cnt = la_cnt - k;
      end
    endfunction

    // Append a plain byte to this step's burst, at most one window's worth
    function void add_byte(ref uee_pkg::res_word_t burst[$], input logic [7:0] b);
      uee_pkg::res_word_t w;
      if (burst.size() >= uee_pkg::LA_DEPTH) return;
      w.data = b;
      w.last = 1'b0;
      w.err  = 1'b0;
      burst.push_back(w);
    endfunction

    // Decode one accepted byte and queue the words it releases
    function void take_byte(logic [7:0] b, logic fin);
      uee_pkg::res_word_t burst[$];
      uee_pkg::res_word_t bad;
      logic [7:0]         h;
      int                 v;
      int                 d;
      bit                 ok;
      if (swallowing) begin
        if (fin) swallowing = 0;
        return;
      end
      if (la_cnt >= uee_pkg::LA_DEPTH) la_cnt = uee_pkg::LA_DEPTH - 1;
      la_buf[la_cnt] = b;
      la_cnt++;
      while (la_cnt > 0) begin
        h = la_buf[0];
        if (h != uee_pkg::CHAR_BSLASH) begin
          add_byte(burst, h);
          drop_front(1);
          continue;
        end
        if (la_cnt < 2) begin
          if (!fin) break;
          add_byte(burst, h);
          drop_front(1);
          continue;
        end
        if (la_buf[1] == uee_pkg::CHAR_U) begin
          // Short escape: wait for more, or pass raw at the string end
          if (la_cnt < uee_pkg::LA_DEPTH) begin
            if (!fin) break;
            add_byte(burst, h);
            drop_front(1);
            continue;
          end
          v = 0;
          ok = 1;
          for (int i = 2; i < uee_pkg::LA_DEPTH; i++) begin
            d = hex_value(la_buf[i]);
            if (d < 0) begin
              ok = 0;
              break;
            end
            v = v * 16 + d;
          end
          // Bad digit: one error word closes the string, drop the rest
          if (!ok) begin
            bad.data = 8'h00;
            bad.last = 1'b1;
            bad.err  = 1'b1;
            expected_words.push_back(bad);
            clear_window();
            if (!fin) swallowing = 1;
            return;
          end
          if (v < int'(uee_pkg::ESC_LIMIT)) begin
            add_byte(burst, v[7:0]);
            drop_front(uee_pkg::LA_DEPTH);
          end else begin
            add_byte(burst, h);
            drop_front(1);
          end
          continue;
        end
        // Backslash pair passes as two bytes
        if (la_buf[1] == uee_pkg::CHAR_BSLASH) begin
          add_byte(burst, h);
          add_byte(burst, la_buf[1]);
          drop_front(2);
          continue;
        end
        add_byte(burst, h);
        drop_front(1);
      end
      if (fin) begin
        clear_window();
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      end
      foreach (burst[i]) expected_words.push_back(burst[i]);
    endfunction

    // Compare one output word against the oldest expectation
    function void check_word(logic [7:0] data, logic last, logic err);
      uee_pkg::res_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %02h string_end %0b parse_error %0b",
               data, last, err);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (data !== w.data) begin
        $error("out_byte: expected %02h, got %02h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("string_end: expected %0b, got %0b", w.last, last);
        errors++;
      end
      if (err !== w.err) begin
        $error("parse_error: expected %0b, got %0b", w.err, err);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  unescape_model model;
  logic [7:0]    str_bytes[$];
  bit            sender_eager;
  int            bytes_sent;
  int            words_seen;
  int            idle_cycles;

  unicode_escape_unescaper u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    model    = new();
  end

  function automatic logic [7:0] hex_char(int d);
    if (d < 10) return 8'("0" + d);
    return ($urandom_range(0, 1) != 0) ? 8'("A" + d - 10) : 8'("a" + d - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (unescape_model::hex_value(c) >= 0);
    return c;
  endfunction

  task automatic push_text(input string txt);
    for (int i = 0; i < txt.len(); i++) str_bytes.push_back(txt[i]);
  endtask

  // Push backslash-u and up to four digits; one digit may be made invalid
  task automatic push_escape(input bit low_value, input int bad_pos, input int ndigits);
    str_bytes.push_back(uee_pkg::CHAR_BSLASH);
    str_bytes.push_back(uee_pkg::CHAR_U);
    for (int i = 0; i < ndigits; i++) begin
      if (i == bad_pos) str_bytes.push_back(non_hex_char());
      else if (low_value && i < 2) str_bytes.push_back("0");
      else str_bytes.push_back(hex_char($urandom_range(0, 15)));
    end
  endtask

  // Random bytes and well-formed escapes, plus backslash pairs, broken and short escapes
  task automatic build_random_string();
    int nseg;
    int len;
    str_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) str_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nseg = $urandom_range(1, 3);
    repeat (nseg) begin
      case ($urandom_range(0, 9))
        0, 1, 2: str_bytes.push_back(8'($urandom_range(0, 255)));
        3, 4, 5: push_escape($urandom_range(0, 1), -1, 4);
        6: begin
          str_bytes.push_back(uee_pkg::CHAR_BSLASH);
          str_bytes.push_back(uee_pkg::CHAR_BSLASH);
        end
        7: push_escape($urandom_range(0, 1), $urandom_range(0, 3), 4);
        8: begin
          str_bytes.push_back(uee_pkg::CHAR_BSLASH);
          str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: push_escape($urandom_range(0, 1), -1, $urandom_range(0, 3));
      endcase
    end
  endtask

  // Offer one word and hold it until taken; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = fin;
    do @(posedge clk); while (!s_tready);
    model.take_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string();
    sender_eager = ($urandom_range(0, 3) == 0);
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  task automatic wait_for_drain();
    s_tvalid = 1'b0;
    while (model.pending() != 0) @(negedge clk);
  endtask

  // Sink: random stalls, quiet stretches, and one long hold-off
  initial begin
    int  gap;
    bit  eager;
    bit  held;
    eager = 0;
    held  = 0;
    words_seen = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && words_seen >= HOLD_AT_WORD) begin
        held = 1;
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) eager = !eager;
      gap = eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      model.check_word(m_tdata, m_tlast, m_tuser);
      words_seen++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus: directed strings, then random strings
  initial begin
    bit paused;
    paused = 0;
    bytes_sent = 0;
    sender_eager = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // single top byte
    str_bytes.delete();
    str_bytes.push_back(8'hFF);
    send_string();
    // zero byte, then the largest value that still decodes, mixed case
    str_bytes.delete();
    str_bytes.push_back(8'h00);
    push_text("\\u00fE");
    send_string();
    // backslash pair, then an escape of 255 that passes through raw
    str_bytes.delete();
    push_text("\\\\\\u00FF");
    send_string();
    // short tail after backslash-u
    str_bytes.delete();
    push_text("\\u12");
    send_string();
    // lone backslash at the string end
    str_bytes.delete();
    push_text("\\");
    send_string();
    // bad digit mid-string, rest swallowed
    str_bytes.delete();
    push_text("\\u0g12Z");
    send_string();
    // bad digit in an escape that ends the string
    str_bytes.delete();
    push_text("\\u00z1");
    send_string();
    wait_for_drain();

    while (bytes_sent < RANDOM_BYTES) begin
      build_random_string();
      send_string();
      if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
        paused = 1;
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ unicode_escape_unescaper.f @@
sv/uee_pkg.sv
sv/unicode_escape_unescaper.sv
tb/sv/unicode_escape_unescaper_tb.sv
